/* hdl/urdc_pkg.sv */
// Package for the register datagram framer with CRC-8.
// Holds the command and entry codes, the queue entry type and the CRC-8 byte update.
// No dependencies.
package urdc_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam logic [2:0] READ_LAST_IDX  = 3'd3;
    localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
    localparam logic [2:0] REPLY_LAST_CNT = 3'd7;
    localparam logic [2:0] REPLY_VALUE_CNT = 3'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  node_address;
        logic [6:0]  register_address;
        logic [31:0] data;
        logic        reply_done;
        logic        reply_crc_ok;
    } entry_t;

    // One byte through the CRC-8, least significant bit first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] b;
        c = crc_in;
        b = data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7] ^ b[0])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
            b = {1'b0, b[7:1]};
        end
        return c;
    endfunction

endpackage

/* hdl/urdc_req_if.sv */
// Request channel of the datagram framer: valid, ready and the request fields.
// Depends on nothing.
interface urdc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  node_address;
    logic [6:0]  register_address;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;

    modport source (output valid, output command, output node_address,
                    output register_address, output write_value, output rx_byte,
                    input ready);
    modport sink (input valid, input command, input node_address,
                  input register_address, input write_value, input rx_byte,
                  output ready);
endinterface

/* hdl/urdc_rsp_if.sv */
// Result channel of the datagram framer: valid, ready and the result fields.
// Depends on nothing.
interface urdc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        tx_last;
    logic [31:0] reply_value;
    logic        reply_done;
    logic        reply_crc_ok;

    modport source (output valid, output tx_byte, output tx_valid, output tx_last,
                    output reply_value, output reply_done, output reply_crc_ok,
                    input ready);
    modport sink (input valid, input tx_byte, input tx_valid, input tx_last,
                  input reply_value, input reply_done, input reply_crc_ok,
                  output ready);
endinterface

/* hdl/uart_register_datagram_crc8.sv */
// Register datagram framer with CRC-8 (polynomial 0x07, LSB-first bytes).
// Request channel req: command 0 reads, 1 writes, 2 hands in one reply byte.
// Result channel rsp: one transfer per datagram byte, or one per reply byte.
// A read request gives four byte transfers, a write request eight, the last
// marked by tx_last and carrying the CRC. Each reply byte gives one transfer
// with tx_valid low; the eighth carries reply_value, reply_done and
// reply_crc_ok. A read request clears the reply count.
// Each read, write or reply request is written into the queue; the output
// register loads each result from the queue head, and it transfers when
// rsp.ready is high. Throughput: one result transfer per cycle while rsp.ready
// is high and the queue is not empty; a write request occupies the back end
// for eight transfers, a read for four, a reply byte for one. A four-entry
// queue lets requests be taken while the back end is busy. Reset empties the
// queue and the output register and zeroes the reply state. When rsp stalls,
// the output holds, the queue fills and req.ready drops once four entries wait.
// Depends on urdc_pkg, urdc_req_if, urdc_rsp_if, urdc_front, urdc_queue, urdc_back.
module uart_register_datagram_crc8
    import urdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    urdc_req_if.sink    req,
    urdc_rsp_if.source  rsp
);

    logic   push, pop, queue_full, queue_empty;
    entry_t push_entry, head;

    urdc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    urdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .empty      (queue_empty),
        .head       (head)
    );

    urdc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .rsp         (rsp)
    );

endmodule

/* hdl/urdc_front.sv */
// Front end: accepts requests, tracks the reply byte count, CRC and value,
// and builds queue entries. Depends on urdc_pkg and urdc_req_if.
module urdc_front
    import urdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    urdc_req_if.sink     req,
    input  logic         queue_full,
    output logic         push,
    output entry_t       push_entry
);

    logic [2:0]  reply_count_reg, reply_count_next;
    logic [7:0]  reply_crc_reg, reply_crc_next;
    logic [31:0] reply_shift_reg, reply_shift_next;
    logic        take;
    logic [7:0]  crc_upd;

    assign req.ready = !queue_full;
    assign take      = req.valid && req.ready;
    assign push      = take && (req.command != CMD_NONE);
    assign crc_upd   = crc8_feed(reply_crc_reg, req.rx_byte);

    always_comb
    begin
        reply_count_next = reply_count_reg;
        reply_crc_next   = reply_crc_reg;
        reply_shift_next = reply_shift_reg;
        push_entry.kind             = req.command;
        push_entry.node_address     = req.node_address;
        push_entry.register_address = req.register_address;
        push_entry.data             = req.write_value;
        push_entry.reply_done       = 1'b0;
        push_entry.reply_crc_ok     = 1'b0;
        if (take)
        begin
            unique case (req.command)
                CMD_READ:
                begin
                    reply_count_next = '0;
                    reply_crc_next   = '0;
                    reply_shift_next = '0;
                end
                CMD_REPLY:
                begin
                    push_entry.data = '0;
                    if (reply_count_reg != REPLY_LAST_CNT)
                    begin
                        reply_crc_next = crc_upd;
                        if (reply_count_reg >= REPLY_VALUE_CNT)
                        begin
                            reply_shift_next = {reply_shift_reg[23:0], req.rx_byte};
                        end
                        reply_count_next = reply_count_reg + 3'd1;
                    end
                    else
                    begin
                        push_entry.data         = reply_shift_reg;
                        push_entry.reply_done   = 1'b1;
                        push_entry.reply_crc_ok = (req.rx_byte == reply_crc_reg);
                        reply_count_next = '0;
                        reply_crc_next   = '0;
                        reply_shift_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_count_reg <= '0;
            reply_crc_reg   <= '0;
            reply_shift_reg <= '0;
        end
        else
        begin
            reply_count_reg <= reply_count_next;
            reply_crc_reg   <= reply_crc_next;
            reply_shift_reg <= reply_shift_next;
        end
    end

endmodule

/* hdl/urdc_queue.sv */
// Short queue of classified entries between the front and back ends.
// Depends on urdc_pkg.
module urdc_queue
    import urdc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output entry_t head
);

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

/* hdl/urdc_back.sv */
// Back end: serializes datagrams one byte per transfer with a running CRC-8
// and forwards reply results. Depends on urdc_pkg and urdc_rsp_if.
module urdc_back
    import urdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  entry_t      head,
    output logic        pop,
    urdc_rsp_if.source  rsp
);

    logic [2:0]  idx_reg;
    logic [7:0]  crc_reg;
    logic        out_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        tx_valid_reg, tx_last_reg;
    logic [31:0] reply_value_reg;
    logic        reply_done_reg, reply_crc_ok_reg;

    logic        advance, is_reply, is_write, at_last;
    logic [2:0]  last_idx;
    logic [7:0]  cur_byte;

    assign advance  = !out_valid_reg || rsp.ready;
    assign is_reply = (head.kind == CMD_REPLY);
    assign is_write = (head.kind == CMD_WRITE);
    assign last_idx = is_write ? WRITE_LAST_IDX : READ_LAST_IDX;
    assign at_last  = (idx_reg == last_idx);
    assign pop      = advance && !queue_empty && (is_reply || at_last);

    always_comb
    begin
        unique case (idx_reg)
            3'd0: cur_byte = SYNC_BYTE;
            3'd1: cur_byte = head.node_address;
            3'd2: cur_byte = {is_write, head.register_address};
            3'd3: cur_byte = is_write ? head.data[31:24] : crc_reg;
            3'd4: cur_byte = head.data[23:16];
            3'd5: cur_byte = head.data[15:8];
            3'd6: cur_byte = head.data[7:0];
            default: cur_byte = crc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= !queue_empty;
            if (!queue_empty && !is_reply)
            begin
                if (at_last)
                begin
                    idx_reg <= '0;
                    crc_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 3'd1;
                    crc_reg <= crc8_feed(crc_reg, cur_byte);
                end
            end
        end
    end

    // Result payload follows the output register; it needs no reset.
    always_ff @(posedge clk)
    begin
        if (advance && !queue_empty)
        begin
            if (is_reply)
            begin
                tx_byte_reg      <= '0;
                tx_valid_reg     <= 1'b0;
                tx_last_reg      <= 1'b0;
                reply_value_reg  <= head.data;
                reply_done_reg   <= head.reply_done;
                reply_crc_ok_reg <= head.reply_crc_ok;
            end
            else
            begin
                tx_byte_reg      <= cur_byte;
                tx_valid_reg     <= 1'b1;
                tx_last_reg      <= at_last;
                reply_value_reg  <= '0;
                reply_done_reg   <= 1'b0;
                reply_crc_ok_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.tx_byte      = tx_byte_reg;
    assign rsp.tx_valid     = tx_valid_reg;
    assign rsp.tx_last      = tx_last_reg;
    assign rsp.reply_value  = reply_value_reg;
    assign rsp.reply_done   = reply_done_reg;
    assign rsp.reply_crc_ok = reply_crc_ok_reg;

endmodule

/* hdl/urdc_checker.sv */
// Port-level checker for the datagram framer's result channel, with its bind.
// Depends on uart_register_datagram_crc8 and urdc_rsp_if.
module urdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [7:0]  rsp_tx_byte,
    input logic        rsp_tx_valid,
    input logic        rsp_tx_last,
    input logic [31:0] rsp_reply_value,
    input logic        rsp_reply_done,
    input logic        rsp_reply_crc_ok
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte))
        else $error("result changed while stalled");

    a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_tx_last |-> rsp_tx_valid)
        else $error("tx_last without tx_valid");

    a_done_not_tx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_reply_done |-> !rsp_tx_valid)
        else $error("reply_done on a transmit transfer");

    a_idle_reply: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_reply_done |-> rsp_reply_value == 32'd0 && !rsp_reply_crc_ok)
        else $error("reply fields set without reply_done");

    a_idle_tx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'd0 && !rsp_tx_last)
        else $error("tx fields set without tx_valid");

endmodule

bind uart_register_datagram_crc8 urdc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_tx_byte      (rsp.tx_byte),
    .rsp_tx_valid     (rsp.tx_valid),
    .rsp_tx_last      (rsp.tx_last),
    .rsp_reply_value  (rsp.reply_value),
    .rsp_reply_done   (rsp.reply_done),
    .rsp_reply_crc_ok (rsp.reply_crc_ok)
);
